/* design/pds_pkg.sv */
// Package for the pair-difference seen-set block: depth, widths and the
// transaction types that travel along the cell chain and into the result buffer.
// No dependencies.
package pds_pkg;

   // Number of cells in the chain, which is also the number of values one set can hold.
   localparam int SetDepth   = 64;
   localparam int ValueWidth = 32;
   // Widened width for exact differences of two signed values.
   localparam int DeltaWidth = ValueWidth + 1;

   // Transaction that moves one cell per cycle along the chain while the chain advances.
   typedef struct packed {
      logic                         valid;
      logic signed [ValueWidth-1:0] value;
      logic                         last;
      logic                         hit;
      logic                         stored;
   } item_type;

   // One result transaction.
   typedef struct packed {
      logic partner_hit;
      logic pair_found;
      logic store_full;
      logic set_done;
   } rsp_type;

endpackage

/* design/pds_cell.sv */
// One cell of the pair-difference chain: holds one stored value of the current set
// and checks each passing transaction against it. Depends on pds_pkg.
module pds_cell
   import pds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [DeltaWidth-1:0] diff_pos,
   input  logic [DeltaWidth-1:0] diff_neg,
   input  item_type              item_in,
   output item_type              item_out
);

   logic                         occupied_ff;
   logic                         occupied_in;
   logic signed [ValueWidth-1:0] value_ff;
   item_type                     item_ff;
   item_type                     item_in_next;
   logic [DeltaWidth-1:0]        delta;
   logic                         match;
   logic                         claim;

   // Exact difference at widened precision.
   assign delta = {value_ff[ValueWidth-1], value_ff}
                - {item_in.value[ValueWidth-1], item_in.value};
   assign match = occupied_ff && ((delta == diff_pos) || (delta == diff_neg));
   // First free cell on the path takes the value.
   assign claim = item_in.valid && !occupied_ff && !item_in.stored;

   always_comb begin
      item_in_next        = item_in;
      item_in_next.hit    = item_in.hit | match;
      item_in_next.stored = item_in.stored | claim;

      occupied_in = occupied_ff;
      if (item_in.valid) begin
         if (item_in.last) begin
            // drop the set once its final transaction has passed
            occupied_in = 1'b0;
         end else if (claim) begin
            occupied_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff   <= 1'b0;
         item_ff.valid <= 1'b0;
      end else if (advance) begin
         occupied_ff <= occupied_in;
         item_ff     <= item_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && claim) begin
         value_ff <= item_in.value;
      end
   end

   assign item_out = item_ff;

endmodule

/* design/pds_rsp_buffer.sv */
// Two-entry result buffer between the end of the cell chain and the result channel.
// Depends on pds_pkg.
module pds_rsp_buffer
   import pds_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output rsp_type head
);

   rsp_type    entry_ff [2];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       rd_ptr_ff;
   logic       wr_ptr_ff;

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

endmodule

/* design/pair_difference_seen_set.sv */
// Top level of the pair-difference seen-set block: a chain of pds_cell stages
// feeding a two-entry result buffer. Depends on pds_pkg, pds_cell and pds_rsp_buffer.
//
// Usage:
//   req_ channel: one signed value per transaction plus an end-of-set mark.
//   rsp_ channel: one result per request, in order: partner hit, sticky found,
//     sticky store-full and an echo of the end-of-set mark.
//   csr_ channel: writes the target difference; csr_ready is always high.
//     Write it only while no transaction is in flight.
// Throughput: one transaction per cycle while req_stall is low. Values travel
//   one cell per cycle, while the chain advances, down a row of SetDepth cells;
//   each cell keeps one value of the set and compares every later value as it
//   passes, so the chain of cells sets the rate.
// Path: a request passes SetDepth cell stages, then one buffer write, after which
//   rsp_valid shows the result.
// Reset: synchronous, active high; clears all cells, the sticky flags, the
//   result buffer and the difference register (difference 0). No clearing pass.
// Stall: when rsp_stall holds results back, the two-entry buffer fills, the
//   whole chain freezes and req_stall is high for as long as the buffer is full.
//   Nothing is lost; results resume in order once rsp_stall drops.
module pair_difference_seen_set
   import pds_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [ValueWidth-1:0] req_sample_value,
   input  logic                         req_ends_set,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_partner_hit,
   output logic                         rsp_pair_found,
   output logic                         rsp_store_full,
   output logic                         rsp_set_done,

   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic signed [ValueWidth-1:0] csr_data
);

   // Target difference held in both signs, widened so no compare can wrap.
   logic [DeltaWidth-1:0] diff_pos_ff;
   logic [DeltaWidth-1:0] diff_neg_ff;

   item_type chain [SetDepth+1];
   item_type tail;

   logic    advance;
   logic    buf_full;
   logic    buf_not_empty;
   logic    push;
   logic    pop;
   rsp_type push_data;
   rsp_type head;

   logic found_ff;
   logic found_in;
   logic overflow_ff;
   logic overflow_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_pos_ff <= '0;
         diff_neg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         diff_pos_ff <= {csr_data[ValueWidth-1], csr_data};
         diff_neg_ff <= DeltaWidth'(0) - {csr_data[ValueWidth-1], csr_data};
      end
   end

   // Advance the whole chain whenever the buffer has room for the tail transaction.
   assign advance   = !buf_full;
   assign req_stall = !advance;

   always_comb begin
      chain[0].valid  = req_valid;
      chain[0].value  = req_sample_value;
      chain[0].last   = req_ends_set;
      chain[0].hit    = 1'b0;
      chain[0].stored = 1'b0;
   end

   for (genvar k = 0; k < SetDepth; k++) begin : g_cell
      pds_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .diff_pos (diff_pos_ff),
         .diff_neg (diff_neg_ff),
         .item_in  (chain[k]),
         .item_out (chain[k+1])
      );
   end

   assign tail = chain[SetDepth];

   // A transaction that found no free cell was not stored: the set overflowed.
   always_comb begin
      push                  = advance && tail.valid;
      push_data.partner_hit = tail.hit;
      push_data.pair_found  = found_ff | tail.hit;
      push_data.store_full  = overflow_ff | !tail.stored;
      push_data.set_done    = tail.last;

      found_in    = found_ff;
      overflow_in = overflow_ff;
      if (push) begin
         if (tail.last) begin
            // clear sticky flags after the final transaction of the set
            found_in    = 1'b0;
            overflow_in = 1'b0;
         end else begin
            found_in    = push_data.pair_found;
            overflow_in = push_data.store_full;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff    <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         found_ff    <= found_in;
         overflow_ff <= overflow_in;
      end
   end

   assign pop = buf_not_empty && !rsp_stall;

   pds_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (buf_full),
      .not_empty (buf_not_empty),
      .head      (head)
   );

   assign rsp_valid       = buf_not_empty;
   assign rsp_partner_hit = head.partner_hit;
   assign rsp_pair_found  = head.pair_found;
   assign rsp_store_full  = head.store_full;
   assign rsp_set_done    = head.set_done;

   // An accepted request occupies the first cell on the next cycle.
   a_req_enters_chain: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> chain[1].valid)
      else $error("accepted request did not enter the cell chain");

   // A hit is always reflected in the sticky found flag of the same result.
   a_hit_implies_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_partner_hit || rsp_pair_found))
      else $error("partner hit without pair found");

   // Sticky flags clear once the end of a set leaves the chain.
   a_flags_clear_at_end: assert property (@(posedge clock) disable iff (reset)
      (push && tail.last) |=> (!found_ff && !overflow_ff))
      else $error("sticky flags not cleared after end of set");

endmodule
